FILE: rtl/complex_arithmetic_unit_core_assert.svh
// Assertion macros used by the checker file of this block.
// Each macro samples on the rising clock and is disabled while reset is low.
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CAU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/cau_pkg.sv
package cau_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;

	localparam int OP_BITS     = 4;
	localparam int STATUS_BITS = 2;

	typedef logic [OP_BITS-1:0]     op_t;
	typedef logic [STATUS_BITS-1:0] status_t;

	localparam op_t OP_SUM   = 4'd0;
	localparam op_t OP_DIFF  = 4'd1;
	localparam op_t OP_PROD  = 4'd2;
	localparam op_t OP_QUOT  = 4'd3;
	localparam op_t OP_CONJ  = 4'd4;
	localparam op_t OP_SCALE = 4'd5;
	localparam op_t OP_NORM  = 4'd6;
	localparam op_t OP_MAG   = 4'd7;
	localparam op_t OP_EQUAL = 4'd8;

	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_SAT  = 2'd1;
	localparam status_t ST_DIV0 = 2'd2;

	// How the final stage builds the result of a word.
	typedef enum logic [1:0] {
		KIND_SIMPLE = 2'd0,
		KIND_DIV    = 2'd1,
		KIND_SQRT   = 2'd2
	} kind_t;

	// Control that travels with each word from stage to stage.
	typedef struct packed {
		logic  valid;
		kind_t kind;
		logic  neg_re;
		logic  neg_im;
	} ctl_t;

endpackage

FILE: rtl/cau_in_if.sv
interface cau_in_if #(
	parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF
);
	import cau_pkg::*;

	logic                        valid;
	logic                        ready;
	op_t                         op;
	logic signed [WORD_BITS-1:0] a_real;
	logic signed [WORD_BITS-1:0] a_imag;
	logic signed [WORD_BITS-1:0] b_real;
	logic signed [WORD_BITS-1:0] b_imag;

	modport source (output valid, op, a_real, a_imag, b_real, b_imag, input ready);
	modport sink   (input valid, op, a_real, a_imag, b_real, b_imag, output ready);

endinterface

FILE: rtl/cau_out_if.sv
interface cau_out_if #(
	parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF
);
	import cau_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] res_real;
	logic signed [WORD_BITS-1:0] res_imag;
	status_t                     status;

	modport source (output valid, res_real, res_imag, status, input ready);
	modport sink   (input valid, res_real, res_imag, status, output ready);

endinterface

FILE: rtl/cau_front.sv
module cau_front #(
	parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	cau_in_if.sink                              operand,
	output cau_pkg::ctl_t                       ctl_o,
	input  logic                                ready_i,
	output logic [2*WORD_BITS+FRAC_BITS-1:0]    nq_re_o,
	output logic [2*WORD_BITS+FRAC_BITS-1:0]    nq_im_o,
	output logic [2*WORD_BITS-1:0]              den_o,
	output logic [2*WORD_BITS-1:0]              sqn_o,
	output logic [WORD_BITS-1:0]                sres_re_o,
	output logic [WORD_BITS-1:0]                sres_im_o,
	output cau_pkg::status_t                    sstat_o
);
	import cau_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int PW = 2*W + 1;
	localparam int QW = 2*W + F;

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	assign rdy3 = !v_s3 || ready_i;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign operand.ready = rdy1;

	// Stage 1: the six products.
	op_t                  op_s1;
	logic signed [W-1:0]  ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [2*W-1:0] prr_s1, pii_s1, pri_s1, pir_s1, pxx_s1, pyy_s1;
	logic                 sq_sel;
	logic signed [W-1:0]  x_sel, y_sel;

	assign sq_sel = (operand.op == OP_NORM) || (operand.op == OP_MAG);
	assign x_sel  = sq_sel ? operand.a_real : operand.b_real;
	assign y_sel  = sq_sel ? operand.a_imag : operand.b_imag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= operand.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && operand.valid) begin
			op_s1  <= operand.op;
			ar_s1  <= operand.a_real;
			ai_s1  <= operand.a_imag;
			br_s1  <= operand.b_real;
			bi_s1  <= operand.b_imag;
			prr_s1 <= operand.a_real * operand.b_real;
			pii_s1 <= operand.a_imag * operand.b_imag;
			pri_s1 <= operand.a_real * operand.b_imag;
			pir_s1 <= operand.a_imag * operand.b_real;
			pxx_s1 <= x_sel * x_sel;
			pyy_s1 <= y_sel * y_sel;
		end
	end

	// Stage 2: sums of products and the wide value of the simple operations.
	function automatic logic signed [PW-1:0] sxw(input logic [W-1:0] v);
		return $signed({{(PW-W){v[W-1]}}, v});
	endfunction

	logic signed [PW-1:0] e_rr, e_ii, e_ri, e_ir;
	logic signed [PW-1:0] pr_re_c, pr_im_c;
	logic signed [PW-1:0] w_re_c, w_im_c;
	logic [2*W-1:0]       nrm_c;
	logic                 bz_c, eq_c;

	assign e_rr    = $signed({prr_s1[2*W-1], prr_s1});
	assign e_ii    = $signed({pii_s1[2*W-1], pii_s1});
	assign e_ri    = $signed({pri_s1[2*W-1], pri_s1});
	assign e_ir    = $signed({pir_s1[2*W-1], pir_s1});
	assign pr_re_c = e_rr - e_ii;
	assign pr_im_c = e_ri + e_ir;
	assign nrm_c   = $unsigned(pxx_s1) + $unsigned(pyy_s1);
	assign bz_c    = (br_s1 == '0) && (bi_s1 == '0);
	assign eq_c    = (ar_s1 == br_s1) && (ai_s1 == bi_s1);

	always_comb begin
		w_re_c = '0;
		w_im_c = '0;
		case (op_s1)
			OP_SUM: begin
				w_re_c = sxw(ar_s1) + sxw(br_s1);
				w_im_c = sxw(ai_s1) + sxw(bi_s1);
			end
			OP_DIFF: begin
				w_re_c = sxw(ar_s1) - sxw(br_s1);
				w_im_c = sxw(ai_s1) - sxw(bi_s1);
			end
			OP_PROD: begin
				w_re_c = pr_re_c >>> F;
				w_im_c = pr_im_c >>> F;
			end
			OP_CONJ: begin
				w_re_c = sxw(ar_s1);
				w_im_c = -sxw(ai_s1);
			end
			OP_SCALE: begin
				w_re_c = e_rr >>> F;
				w_im_c = e_ir >>> F;
			end
			OP_NORM: begin
				w_re_c = $signed({1'b0, nrm_c >> F});
			end
			OP_EQUAL: begin
				w_re_c = $signed({{(PW-1){1'b0}}, eq_c});
			end
			default: begin
				w_re_c = '0;
				w_im_c = '0;
			end
		endcase
	end

	op_t                  op_s2;
	logic signed [PW-1:0] w_re_s2, w_im_s2, q_re_s2, q_im_s2;
	logic [2*W-1:0]       nrm_s2;
	logic                 bz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			op_s2   <= op_s1;
			w_re_s2 <= w_re_c;
			w_im_s2 <= w_im_c;
			q_re_s2 <= e_rr + e_ii;
			q_im_s2 <= e_ir - e_ri;
			nrm_s2  <= nrm_c;
			bz_s2   <= bz_c;
		end
	end

	// Stage 3: clamp the simple result, set up the divider and the root.
	function automatic logic [W:0] sat_pw(input logic [PW-1:0] v);
		logic [PW-W:0] hi;
		logic          fits;
		hi   = v[PW-1:W-1];
		fits = (&hi) || !(|hi);
		if (fits) begin
			return {1'b0, v[W-1:0]};
		end else if (v[PW-1]) begin
			return {1'b1, 1'b1, {(W-1){1'b0}}};
		end else begin
			return {1'b1, 1'b0, {(W-1){1'b1}}};
		end
	endfunction

	logic [W:0]           s_re_c, s_im_c;
	logic signed [PW-1:0] m_re_c, m_im_c;
	logic                 div0_c;
	kind_t                kind_c;
	status_t              stat_c;

	assign s_re_c = sat_pw(w_re_s2);
	assign s_im_c = sat_pw(w_im_s2);
	assign m_re_c = q_re_s2[PW-1] ? -q_re_s2 : q_re_s2;
	assign m_im_c = q_im_s2[PW-1] ? -q_im_s2 : q_im_s2;
	assign div0_c = (op_s2 == OP_QUOT) && bz_s2;

	always_comb begin
		if (div0_c) begin
			stat_c = ST_DIV0;
		end else if (s_re_c[W] || s_im_c[W]) begin
			stat_c = ST_SAT;
		end else begin
			stat_c = ST_OK;
		end
		if ((op_s2 == OP_QUOT) && !bz_s2) begin
			kind_c = KIND_DIV;
		end else if (op_s2 == OP_MAG) begin
			kind_c = KIND_SQRT;
		end else begin
			kind_c = KIND_SIMPLE;
		end
	end

	kind_t               kind_s3;
	logic                neg_re_s3, neg_im_s3;
	logic [QW-1:0]       nq_re_s3, nq_im_s3;
	logic [2*W-1:0]      den_s3;
	logic [W-1:0]        sres_re_s3, sres_im_s3;
	status_t             sstat_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			kind_s3    <= kind_c;
			neg_re_s3  <= q_re_s2[PW-1];
			neg_im_s3  <= q_im_s2[PW-1];
			nq_re_s3   <= {m_re_c[2*W-1:0], {F{1'b0}}};
			nq_im_s3   <= {m_im_c[2*W-1:0], {F{1'b0}}};
			den_s3     <= nrm_s2;
			sres_re_s3 <= s_re_c[W-1:0];
			sres_im_s3 <= s_im_c[W-1:0];
			sstat_s3   <= stat_c;
		end
	end

	assign ctl_o.valid  = v_s3;
	assign ctl_o.kind   = kind_s3;
	assign ctl_o.neg_re = neg_re_s3;
	assign ctl_o.neg_im = neg_im_s3;
	assign nq_re_o      = nq_re_s3;
	assign nq_im_o      = nq_im_s3;
	assign den_o        = den_s3;
	assign sqn_o        = den_s3;
	assign sres_re_o    = sres_re_s3;
	assign sres_im_o    = sres_im_s3;
	assign sstat_o      = sstat_s3;

endmodule

FILE: rtl/cau_cell.sv
module cau_cell #(
	parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
	parameter int IDX       = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cau_pkg::ctl_t                    ctl_i,
	output logic                             ready_o,
	output cau_pkg::ctl_t                    ctl_o,
	input  logic                             ready_i,
	input  logic [2*WORD_BITS+FRAC_BITS-1:0] nq_re_i,
	input  logic [2*WORD_BITS+FRAC_BITS-1:0] nq_im_i,
	input  logic [2*WORD_BITS-1:0]           rem_re_i,
	input  logic [2*WORD_BITS-1:0]           rem_im_i,
	input  logic [2*WORD_BITS-1:0]           den_i,
	input  logic [2*WORD_BITS-1:0]           sqn_i,
	input  logic [WORD_BITS+1:0]             sqr_i,
	input  logic [WORD_BITS-1:0]             sqt_i,
	input  logic [WORD_BITS-1:0]             sres_re_i,
	input  logic [WORD_BITS-1:0]             sres_im_i,
	input  cau_pkg::status_t                 sstat_i,
	output logic [2*WORD_BITS+FRAC_BITS-1:0] nq_re_o,
	output logic [2*WORD_BITS+FRAC_BITS-1:0] nq_im_o,
	output logic [2*WORD_BITS-1:0]           rem_re_o,
	output logic [2*WORD_BITS-1:0]           rem_im_o,
	output logic [2*WORD_BITS-1:0]           den_o,
	output logic [2*WORD_BITS-1:0]           sqn_o,
	output logic [WORD_BITS+1:0]             sqr_o,
	output logic [WORD_BITS-1:0]             sqt_o,
	output logic [WORD_BITS-1:0]             sres_re_o,
	output logic [WORD_BITS-1:0]             sres_im_o,
	output cau_pkg::status_t                 sstat_o
);
	import cau_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int QW = 2*W + FRAC_BITS;
	localparam logic SQ_ON = (IDX < W);

	ctl_t ctl_q;

	assign ready_o = !ctl_q.valid || ready_i;

	// One restoring division step on each of the two quotient lanes.
	logic [2*W:0]  t_re, t_im;
	logic          ge_re, ge_im;
	logic [2*W:0]  d_re, d_im;

	assign t_re  = {rem_re_i, nq_re_i[QW-1]};
	assign t_im  = {rem_im_i, nq_im_i[QW-1]};
	assign ge_re = t_re >= {1'b0, den_i};
	assign ge_im = t_im >= {1'b0, den_i};
	assign d_re  = t_re - {1'b0, den_i};
	assign d_im  = t_im - {1'b0, den_i};

	// One digit of the square root; the first W cells carry the root.
	logic [W+3:0]  sr4;
	logic [W+3:0]  strial;
	logic          sge;
	logic [W+3:0]  sdiff;
	logic [W+1:0]  sqr_c;
	logic [W-1:0]  sqt_c;
	logic [2*W-1:0] sqn_c;

	assign sr4    = {sqr_i, sqn_i[2*W-1 -: 2]};
	assign strial = {2'b00, sqt_i, 2'b01};
	assign sge    = sr4 >= strial;
	assign sdiff  = sr4 - strial;

	always_comb begin
		if (SQ_ON) begin
			sqr_c = sge ? sdiff[W+1:0] : sr4[W+1:0];
			sqt_c = {sqt_i[W-2:0], sge};
			sqn_c = {sqn_i[2*W-3:0], 2'b00};
		end else begin
			sqr_c = sqr_i;
			sqt_c = sqt_i;
			sqn_c = sqn_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (ready_o) begin
			ctl_q <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && ctl_i.valid) begin
			nq_re_o   <= {nq_re_i[QW-2:0], ge_re};
			nq_im_o   <= {nq_im_i[QW-2:0], ge_im};
			rem_re_o  <= ge_re ? d_re[2*W-1:0] : t_re[2*W-1:0];
			rem_im_o  <= ge_im ? d_im[2*W-1:0] : t_im[2*W-1:0];
			den_o     <= den_i;
			sqn_o     <= sqn_c;
			sqr_o     <= sqr_c;
			sqt_o     <= sqt_c;
			sres_re_o <= sres_re_i;
			sres_im_o <= sres_im_i;
			sstat_o   <= sstat_i;
		end
	end

	assign ctl_o = ctl_q;

endmodule

FILE: rtl/cau_back.sv
module cau_back #(
	parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cau_pkg::ctl_t                    ctl_i,
	output logic                             ready_o,
	input  logic [2*WORD_BITS+FRAC_BITS-1:0] nq_re_i,
	input  logic [2*WORD_BITS+FRAC_BITS-1:0] nq_im_i,
	input  logic [2*WORD_BITS-1:0]           rem_re_i,
	input  logic [2*WORD_BITS-1:0]           rem_im_i,
	input  logic [WORD_BITS-1:0]             sqt_i,
	input  logic [WORD_BITS-1:0]             sres_re_i,
	input  logic [WORD_BITS-1:0]             sres_im_i,
	input  cau_pkg::status_t                 sstat_i,
	cau_out_if.source                        result
);
	import cau_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int QW = 2*W + FRAC_BITS;

	// Floor of a signed quotient from the magnitude and the remainder.
	function automatic logic [QW:0] fix_q(input logic [QW-1:0] q, input logic [2*W-1:0] r,
		input logic neg);
		logic [QW:0] qe;
		qe = {1'b0, q};
		if (!neg) begin
			return qe;
		end else if (|r) begin
			return ~qe;
		end else begin
			return -qe;
		end
	endfunction

	function automatic logic [W:0] sat_q(input logic [QW:0] v);
		logic [QW-W+1:0] hi;
		logic            fits;
		hi   = v[QW:W-1];
		fits = (&hi) || !(|hi);
		if (fits) begin
			return {1'b0, v[W-1:0]};
		end else if (v[QW]) begin
			return {1'b1, 1'b1, {(W-1){1'b0}}};
		end else begin
			return {1'b1, 1'b0, {(W-1){1'b1}}};
		end
	endfunction

	logic [W:0]   dq_re, dq_im;
	logic [W-1:0] re_c, im_c;
	status_t      st_c;

	assign dq_re = sat_q(fix_q(nq_re_i, rem_re_i, ctl_i.neg_re));
	assign dq_im = sat_q(fix_q(nq_im_i, rem_im_i, ctl_i.neg_im));

	always_comb begin
		case (ctl_i.kind)
			KIND_DIV: begin
				re_c = dq_re[W-1:0];
				im_c = dq_im[W-1:0];
				st_c = (dq_re[W] || dq_im[W]) ? ST_SAT : ST_OK;
			end
			KIND_SQRT: begin
				re_c = sqt_i[W-1] ? {1'b0, {(W-1){1'b1}}} : sqt_i;
				im_c = '0;
				st_c = sqt_i[W-1] ? ST_SAT : ST_OK;
			end
			default: begin
				re_c = sres_re_i;
				im_c = sres_im_i;
				st_c = sstat_i;
			end
		endcase
	end

	logic         v_q;
	logic [W-1:0] res_re_q, res_im_q;
	status_t      stat_q;

	assign ready_o = !v_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ready_o) begin
			v_q <= ctl_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && ctl_i.valid) begin
			res_re_q <= re_c;
			res_im_q <= im_c;
			stat_q   <= st_c;
		end
	end

	assign result.valid    = v_q;
	assign result.res_real = res_re_q;
	assign result.res_imag = res_im_q;
	assign result.status   = stat_q;

endmodule

FILE: rtl/complex_arithmetic_unit_core.sv
// Fixed-point complex ALU. Each input word carries an opcode and two signed complex
// operands with FRAC_BITS fraction bits; each output word carries one complex result
// and a status (ok, saturated, divide by zero). The unit is fully pipelined and takes
// one word per cycle, sustained, for every opcode mix, while the output is not
// stalled. All words walk the same path: three setup stages (products, sums,
// clamping and divider setup), a chain of 2*WORD_BITS + FRAC_BITS divider cells
// that each settle one quotient bit, and one output stage. The chain length is what
// sets the latency. Results leave in order. Empty slots in the pipeline close up
// while the output is stalled, so the input keeps taking words until every stage
// holds one.

module complex_arithmetic_unit_core #(
	parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	cau_in_if.sink    operand,
	cau_out_if.source result
);
	import cau_pkg::*;

	localparam int W     = WORD_BITS;
	localparam int QW    = 2*W + FRAC_BITS;
	// One cell per quotient bit. The root needs only the first W cells, and the
	// later cells hand its lanes on unchanged.
	localparam int CELLS = QW;

	// Link i feeds cell i; link CELLS feeds the output stage.
	ctl_t           ctl     [CELLS+1];
	logic           rdy     [CELLS+1];
	logic [QW-1:0]  nq_re   [CELLS+1];
	logic [QW-1:0]  nq_im   [CELLS+1];
	logic [2*W-1:0] rem_re  [CELLS+1];
	logic [2*W-1:0] rem_im  [CELLS+1];
	logic [2*W-1:0] den     [CELLS+1];
	logic [2*W-1:0] sqn     [CELLS+1];
	logic [W+1:0]   sqr     [CELLS+1];
	logic [W-1:0]   sqt     [CELLS+1];
	logic [W-1:0]   sres_re [CELLS+1];
	logic [W-1:0]   sres_im [CELLS+1];
	status_t        sstat   [CELLS+1];

	// The setup stages form the multiplier products, the simple results and the
	// magnitudes of the two quotient numerators, already scaled by 2^FRAC_BITS.
	cau_front #(
		.WORD_BITS (WORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.operand   (operand),
		.ctl_o     (ctl[0]),
		.ready_i   (rdy[0]),
		.nq_re_o   (nq_re[0]),
		.nq_im_o   (nq_im[0]),
		.den_o     (den[0]),
		.sqn_o     (sqn[0]),
		.sres_re_o (sres_re[0]),
		.sres_im_o (sres_im[0]),
		.sstat_o   (sstat[0])
	);

	// Partial remainders and the partial root start from zero.
	assign rem_re[0] = '0;
	assign rem_im[0] = '0;
	assign sqr[0]    = '0;
	assign sqt[0]    = '0;

	// Each cell shifts the numerator out at the top and the new quotient bit in at the
	// bottom of the same register, so after the last cell that register is the
	// unsigned quotient and the remainder is final.
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		cau_cell #(
			.WORD_BITS (WORD_BITS),
			.FRAC_BITS (FRAC_BITS),
			.IDX       (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl_i     (ctl[i]),
			.ready_o   (rdy[i]),
			.ctl_o     (ctl[i+1]),
			.ready_i   (rdy[i+1]),
			.nq_re_i   (nq_re[i]),
			.nq_im_i   (nq_im[i]),
			.rem_re_i  (rem_re[i]),
			.rem_im_i  (rem_im[i]),
			.den_i     (den[i]),
			.sqn_i     (sqn[i]),
			.sqr_i     (sqr[i]),
			.sqt_i     (sqt[i]),
			.sres_re_i (sres_re[i]),
			.sres_im_i (sres_im[i]),
			.sstat_i   (sstat[i]),
			.nq_re_o   (nq_re[i+1]),
			.nq_im_o   (nq_im[i+1]),
			.rem_re_o  (rem_re[i+1]),
			.rem_im_o  (rem_im[i+1]),
			.den_o     (den[i+1]),
			.sqn_o     (sqn[i+1]),
			.sqr_o     (sqr[i+1]),
			.sqt_o     (sqt[i+1]),
			.sres_re_o (sres_re[i+1]),
			.sres_im_o (sres_im[i+1]),
			.sstat_o   (sstat[i+1])
		);
	end

	// The output stage restores the quotient sign with a floor, clamps it, picks the
	// result by kind and holds it in the output register.
	cau_back #(
		.WORD_BITS (WORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_i     (ctl[CELLS]),
		.ready_o   (rdy[CELLS]),
		.nq_re_i   (nq_re[CELLS]),
		.nq_im_i   (nq_im[CELLS]),
		.rem_re_i  (rem_re[CELLS]),
		.rem_im_i  (rem_im[CELLS]),
		.sqt_i     (sqt[CELLS]),
		.sres_re_i (sres_re[CELLS]),
		.sres_im_i (sres_im[CELLS]),
		.sstat_i   (sstat[CELLS]),
		.result    (result)
	);

endmodule

FILE: rtl/cau_checker.sv
module cau_checker #(
	parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic signed [WORD_BITS-1:0] res_real,
	input logic signed [WORD_BITS-1:0] res_imag,
	input cau_pkg::status_t            status
);
	import cau_pkg::*;

	`include "complex_arithmetic_unit_core_assert.svh"

	localparam logic signed [WORD_BITS-1:0] MAXV = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic signed [WORD_BITS-1:0] MINV = {1'b1, {(WORD_BITS-1){1'b0}}};

	`CAU_ASSERT_NEXT(a_hold_valid, clk, arst_n, res_valid && !res_ready, res_valid, "result word dropped while stalled")
	`CAU_ASSERT_NEXT(a_hold_data, clk, arst_n, res_valid && !res_ready, $stable(res_real) && $stable(res_imag) && $stable(status), "stalled result word changed")
	`CAU_ASSERT_NOW(a_div0_zero, clk, arst_n, res_valid && (status == ST_DIV0), (res_real == '0) && (res_imag == '0), "divide by zero without a zero result")
	`CAU_ASSERT_NOW(a_sat_limit, clk, arst_n, res_valid && (status == ST_SAT), (res_real == MAXV) || (res_real == MINV) || (res_imag == MAXV) || (res_imag == MINV), "saturation without a clamped part")

endmodule

bind complex_arithmetic_unit_core cau_checker #(
	.WORD_BITS (WORD_BITS)
) u_cau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_real  (result.res_real),
	.res_imag  (result.res_imag),
	.status    (result.status)
);
